[rtl/core/tahv_pkg.sv]
// ============================================================================
// Tile asset header validator package
// Shared constants, controller/datapath interface types and helpers.
// ============================================================================
package tahv_pkg;

    localparam int HDR_BYTES = 32;
    localparam int HDR_IDX_W = $clog2(HDR_BYTES);

    localparam logic [7:0]  MAGIC_0       = 8'h50;
    localparam logic [7:0]  MAGIC_1       = 8'h54;
    localparam logic [7:0]  MAGIC_2       = 8'h42;
    localparam logic [7:0]  MAGIC_3       = 8'h47;
    localparam logic [15:0] FMT_VERSION   = 16'd1;
    localparam logic [7:0]  MAX_PATTERNS  = 8'd128;
    localparam logic [7:0]  MIN_TILE_DIM  = 8'd8;
    localparam logic [33:0] ALIGN_SLACK   = 34'd3;

    localparam int OUT_DATA_W = 96;

    typedef struct packed {
        logic accept;
        logic check;
        logic calc1;
        logic calc2;
        logic verd;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr_last;
    } t_dp_status;

    function automatic logic tile_dim_ok(input logic [7:0] v);
        tile_dim_ok = (v >= MIN_TILE_DIM) && ((v & (v - 8'd1)) == 8'd0);
    endfunction

endpackage

[rtl/core/tahv_ctrl.sv]
// ============================================================================
// Tile asset header validator controller
// Sequences header capture, table bound setup, body checking and verdict.
// ============================================================================
module tahv_ctrl
    import tahv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tlast,
    output logic       o_s_tready,
    input  logic       i_m_tready,
    output logic       o_m_tvalid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_HDR   = 6'b000001,
        S_CALC1 = 6'b000010,
        S_CALC2 = 6'b000100,
        S_BODY  = 6'b001000,
        S_VERD  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_final, n_final;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_load;

    assign o_s_tready = (r_state == S_HDR) || (r_state == S_BODY);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        o_cmd.check  = w_accept && (r_state == S_BODY);
        o_cmd.calc1  = (r_state == S_CALC1);
        o_cmd.calc2  = (r_state == S_CALC2);
        o_cmd.verd   = (r_state == S_VERD);
        o_cmd.load   = w_load;
    end

    always_comb begin
        n_state     = r_state;
        n_final     = r_final;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_HDR: begin
                if (w_accept) begin
                    n_final = i_s_tlast;
                    if (i_s_tlast || i_status.hdr_last) begin
                        n_state = S_CALC1;
                    end
                end
            end
            S_CALC1: n_state = S_CALC2;
            S_CALC2: n_state = r_final ? S_VERD : S_BODY;
            S_BODY: begin
                if (w_accept && i_s_tlast) begin
                    n_state = S_VERD;
                end
            end
            S_VERD: n_state = S_EMIT;
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_final     = 1'b0;
                    n_state     = S_HDR;
                end
            end
            default: n_state = S_HDR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HDR;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/core/tahv_dp.sv]
// ============================================================================
// Tile asset header validator datapath
// Header registers, byte counter, mapping entry check and verdict logic.
// ============================================================================
module tahv_dp
    import tahv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    input  logic [7:0]            i_byte,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_pack_valid,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic [31:0] r_cfg;
    logic [31:0] r_cnt, n_cnt;
    logic        r_fault, n_fault;
    logic [7:0]  r_hdr [HDR_BYTES];

    logic [15:0] r_tv, r_bm, r_pix;
    logic [32:0] r_tend;
    logic [23:0] r_pbytes;
    logic        r_ok1;

    logic                  r_pack_valid;
    logic [OUT_DATA_W-1:0] r_data;

    logic [31:0] w_mo, w_po, w_ps;
    logic [15:0] w_ver, w_hsize;
    logic [16:0] w_ms;
    logic        w_hdr_ok, w_map_ok, w_pat_ok, w_ok;

    assign w_ver   = {r_hdr[5], r_hdr[4]};
    assign w_hsize = {r_hdr[7], r_hdr[6]};
    assign w_mo    = {r_hdr[19], r_hdr[18], r_hdr[17], r_hdr[16]};
    assign w_po    = {r_hdr[23], r_hdr[22], r_hdr[21], r_hdr[20]};
    assign w_ps    = {r_hdr[27], r_hdr[26], r_hdr[25], r_hdr[24]};
    assign w_ms    = 17'(r_tv) + 17'(r_bm) + 17'(r_hdr[15]);

    assign o_status.hdr_last = (r_cnt == 32'(HDR_BYTES - 1));

    always_comb begin
        n_cnt   = r_cnt;
        n_fault = r_fault;
        if (i_cmd.accept && (r_cnt != '1)) begin
            n_cnt = r_cnt + 32'd1;
        end
        if (i_cmd.check && (r_cnt >= w_mo) && ({1'b0, r_cnt} < r_tend)
                && (i_byte >= r_hdr[10])) begin
            n_fault = 1'b1;
        end
        if (i_cmd.load) begin
            n_cnt   = '0;
            n_fault = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_cnt   <= '0;
            r_fault <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_cnt   <= n_cnt;
            r_fault <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (r_cnt < 32'(HDR_BYTES))) begin
            r_hdr[r_cnt[HDR_IDX_W-1:0]] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            r_tv  <= 16'(r_hdr[11]) * 16'(r_hdr[12]);
            r_bm  <= 16'(r_hdr[13]) * 16'(r_hdr[14]);
            r_pix <= 16'(r_hdr[8]) * 16'(r_hdr[9]);
        end
        if (i_cmd.calc2) begin
            r_tend <= 33'(w_mo) + 33'(w_ms);
        end
        if (i_cmd.verd) begin
            r_pbytes <= 24'(r_hdr[10]) * 24'(r_pix);
            r_ok1    <= w_hdr_ok && w_map_ok && w_pat_ok && (w_ps <= r_cfg) && !r_fault;
        end
        if (i_cmd.load) begin
            r_pack_valid <= w_ok;
            r_data       <= w_ok ? {w_mo, r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12],
                                    r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]} : '0;
        end
    end

    always_comb begin
        w_hdr_ok = (r_cnt >= 32'(HDR_BYTES))
            && (r_hdr[0] == MAGIC_0) && (r_hdr[1] == MAGIC_1)
            && (r_hdr[2] == MAGIC_2) && (r_hdr[3] == MAGIC_3)
            && (w_ver == FMT_VERSION) && (w_hsize == 16'(HDR_BYTES))
            && tile_dim_ok(r_hdr[8]) && tile_dim_ok(r_hdr[9])
            && (r_hdr[10] != 8'd0) && (r_hdr[10] <= MAX_PATTERNS)
            && (r_hdr[11] != 8'd0) && (r_hdr[12] != 8'd0)
            && (r_hdr[13] != 8'd0) && (r_hdr[14] != 8'd0);
        w_map_ok = (w_mo >= 32'(HDR_BYTES)) && (w_mo <= r_cnt)
            && (r_tend <= {1'b0, r_cnt});
        w_pat_ok = ({1'b0, w_po} >= r_tend) && (w_po <= r_cnt)
            && ({2'b00, w_po} <= (34'(r_tend) + ALIGN_SLACK))
            && (w_po[1:0] == 2'b00);
        w_ok     = r_ok1 && (w_ps == 32'(r_pbytes));
    end

    assign o_pack_valid = r_pack_valid;
    assign o_data       = r_data;

endmodule

[rtl/core/tile_asset_header_validator.sv]
// ============================================================================
// Tile asset header validator
// Checks the metadata of a tile-background asset pack and reports a verdict.
// ============================================================================
// Metadata bytes enter on the slave stream, one word per byte, with tlast on
// the final byte. The first 32 bytes form the header; later bytes inside the
// declared mapping table are checked against the pattern count.
// Bytes are taken at one per cycle, except that o_s_tready drops after the
// 32nd byte while the CALC1 and CALC2 states compute the mapping table bounds.
// After the final byte the controller passes through the VERD state for the
// verdict and the EMIT state, which loads the output register once it is
// free (CALC1 and CALC2 come first when the pack ends within the header),
// and no byte is taken during that time.
// The result word holds the decoded header fields, or zeros when any check
// fails, with the pass flag in tuser. It waits in the output register until
// taken; a new pack may stream in meanwhile, and its own result waits until
// the register frees. The user must write the pattern size limit through
// i_cfg_we only while the block is idle; this is not enforced. Reset clears
// the byte count, the fault flag, the limit register and the output valid.
// ============================================================================
module tile_asset_header_validator
    import tahv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // meta_byte[7:0]
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tile_width[7:0], tile_height[15:8], pattern_count[23:16],
    // terrain_count[31:24], variants_per_terrain[39:32], boundary_count[47:40],
    // masks_per_boundary[55:48], object_count[63:56], table_offset[95:64]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser    // pack_valid
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tahv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tahv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_byte       (i_s_tdata),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_pack_valid (o_m_tuser),
        .o_data       (o_m_tdata)
    );

endmodule

[rtl/core/tahv_chk.sv]
// ============================================================================
// Tile asset header validator checker
// Port-level assertions on the verdict stream and the input handshake, bound to the top level.
// ============================================================================
module tahv_chk
    import tahv_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  i_s_tlast,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result word changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("failed verdict carries nonzero fields");

    a_pass_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> tile_dim_ok(o_m_tdata[7:0])
            && tile_dim_ok(o_m_tdata[15:8]) && (o_m_tdata[23:16] != 8'd0)
            && (o_m_tdata[23:16] <= MAX_PATTERNS)
            && (o_m_tdata[95:64] >= 32'(HDR_BYTES)))
        else $error("passed verdict with out-of-range header fields");

    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken right after the final byte");

endmodule

bind tile_asset_header_validator tahv_chk u_tahv_chk (.*);
